>>> rtl/hdmb_pkg.sv
package hdmb_pkg;

	localparam int MAX_NODES = 64;
	localparam int IDX_W = $clog2(MAX_NODES);
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH = 1 << ADDR_W;
	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam int FIELD_W = 6;
	localparam int VAL_W = 7;
	localparam int CFG_W = 7;
	localparam int CMP_W = 16;
	localparam int SUM_W = ((IDX_W > VAL_W) ? IDX_W : VAL_W) + 1;
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;

	localparam logic [VAL_W-1:0] VAL_MAX = '1;
	localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(64);
	localparam logic [PADDR_W-1:0] ADDR_NODE_COUNT = '0;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_WRITE = 2'd1,
		OP_BUILD = 2'd2,
		OP_READ  = 2'd3
	} hdmb_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_HOP_RD,
		S_HOP_CHK,
		S_CUR,
		S_WR2
	} hdmb_state_t;

	typedef struct packed {
		hdmb_op_t             opcode;
		logic [FIELD_W-1:0]   row_index;
		logic [FIELD_W-1:0]   col_index;
		logic [VAL_W-1:0]     entry_value;
	} hdmb_cmd_t;

	typedef struct packed {
		logic [VAL_W-1:0] distance;
		logic             index_ok;
	} hdmb_result_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [VAL_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr;
	} hdmb_ram_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] turn;
		logic [VAL_W-1:0] hop;
		logic [VAL_W-1:0] cur;
	} hdmb_relax_in_t;

	typedef struct packed {
		logic [VAL_W-1:0] cost;
		logic             update;
	} hdmb_relax_out_t;

endpackage

>>> rtl/hdmb_ram.sv
module hdmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/hdmb_relax.sv
module hdmb_relax (
	input  hdmb_pkg::hdmb_relax_in_t  rin,
	output hdmb_pkg::hdmb_relax_out_t rout
);

	localparam int SW = hdmb_pkg::SUM_W;
	localparam int VW = hdmb_pkg::VAL_W;

	logic [SW-1:0] sum;

	always_comb begin
		sum = SW'(rin.turn) + SW'(rin.hop);
		if (sum > SW'(hdmb_pkg::VAL_MAX)) begin
			rout.cost = hdmb_pkg::VAL_MAX;
		end else begin
			rout.cost = VW'(sum);
		end
		rout.update = (rin.cur == '0) || (rin.cur > rout.cost);
	end

endmodule

>>> rtl/hdmb_ctrl.sv
module hdmb_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  hdmb_pkg::hdmb_cmd_t              cmd,
	input  logic [hdmb_pkg::CNT_W-1:0]       n,
	output logic                             busy,
	output logic                             done,
	output hdmb_pkg::hdmb_result_t           result,
	output hdmb_pkg::hdmb_ram_req_t          ram_req,
	input  logic [hdmb_pkg::VAL_W-1:0]       ram_rdata,
	output hdmb_pkg::hdmb_relax_in_t         relax_in,
	input  hdmb_pkg::hdmb_relax_out_t        relax_out
);

	localparam int IW = hdmb_pkg::IDX_W;
	localparam int AW = hdmb_pkg::ADDR_W;
	localparam int CW = hdmb_pkg::CNT_W;
	localparam int MW = hdmb_pkg::CMP_W;
	localparam int SW = hdmb_pkg::SUM_W;
	localparam int VW = hdmb_pkg::VAL_W;

	hdmb_pkg::hdmb_state_t state_q, state_d;
	logic [IW-1:0] turn_q, turn_d, row_q, row_d, col_q, col_d, i_q, i_d;
	logic [AW-1:0] clr_q, clr_d;
	logic [VW-1:0] hop_q, hop_d, cost_q, cost_d;
	logic          rd_pend_q, rd_pend_d, rd_ok_q, rd_ok_d;
	logic          ok, i_adv, scan_adv;
	logic [IW-1:0] n_last, cmd_row, cmd_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hdmb_pkg::S_CLEAR;
			clr_q     <= '0;
			turn_q    <= '0;
			row_q     <= '0;
			col_q     <= '0;
			i_q       <= '0;
			rd_pend_q <= 1'b0;
			rd_ok_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_q     <= clr_d;
			turn_q    <= turn_d;
			row_q     <= row_d;
			col_q     <= col_d;
			i_q       <= i_d;
			rd_pend_q <= rd_pend_d;
			rd_ok_q   <= rd_ok_d;
		end
	end

	always_ff @(posedge clk) begin
		hop_q  <= hop_d;
		cost_q <= cost_d;
	end

	assign ok = (MW'(cmd.row_index) < MW'(n)) && (MW'(cmd.col_index) < MW'(n));
	assign n_last = IW'(n - CW'(1));
	assign cmd_row = IW'(cmd.row_index);
	assign cmd_col = IW'(cmd.col_index);

	assign busy = (state_q != hdmb_pkg::S_IDLE);
	assign done = rd_pend_q;
	assign result.distance = rd_ok_q ? ram_rdata : '0;
	assign result.index_ok = rd_ok_q;

	assign relax_in.turn = turn_q;
	assign relax_in.hop = hop_q;
	assign relax_in.cur = ram_rdata;

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		turn_d    = turn_q;
		row_d     = row_q;
		col_d     = col_q;
		i_d       = i_q;
		hop_d     = hop_q;
		cost_d    = cost_q;
		rd_pend_d = 1'b0;
		rd_ok_d   = rd_ok_q;
		i_adv     = 1'b0;
		scan_adv  = 1'b0;
		ram_req.we    = 1'b0;
		ram_req.waddr = {row_q, i_q};
		ram_req.wdata = '0;
		ram_req.raddr = {row_q, col_q};

		case (state_q)
			hdmb_pkg::S_IDLE: begin
				if (start) begin
					case (cmd.opcode)
						hdmb_pkg::OP_CLEAR: begin
							clr_d   = '0;
							state_d = hdmb_pkg::S_CLEAR;
						end
						hdmb_pkg::OP_WRITE: begin
							ram_req.we    = ok;
							ram_req.waddr = {cmd_row, cmd_col};
							ram_req.wdata = cmd.entry_value;
						end
						hdmb_pkg::OP_BUILD: begin
							if (n > CW'(1)) begin
								turn_d  = IW'(1);
								row_d   = '0;
								col_d   = '0;
								state_d = hdmb_pkg::S_SCAN_RD;
							end
						end
						hdmb_pkg::OP_READ: begin
							ram_req.raddr = {cmd_row, cmd_col};
							rd_pend_d     = 1'b1;
							rd_ok_d       = ok;
						end
						default: begin
						end
					endcase
				end
			end
			hdmb_pkg::S_CLEAR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = clr_q;
				ram_req.wdata = '0;
				clr_d         = clr_q + AW'(1);
				if (&clr_q) begin
					state_d = hdmb_pkg::S_IDLE;
				end
			end
			hdmb_pkg::S_SCAN_RD: begin
				ram_req.raddr = {row_q, col_q};
				state_d       = hdmb_pkg::S_SCAN_CHK;
			end
			hdmb_pkg::S_SCAN_CHK: begin
				if (SW'(ram_rdata) == SW'(turn_q)) begin
					i_d     = '0;
					state_d = hdmb_pkg::S_HOP_RD;
				end else begin
					scan_adv = 1'b1;
				end
			end
			hdmb_pkg::S_HOP_RD: begin
				ram_req.raddr = {col_q, i_q};
				state_d       = hdmb_pkg::S_HOP_CHK;
			end
			hdmb_pkg::S_HOP_CHK: begin
				hop_d = ram_rdata;
				if (ram_rdata == '0) begin
					i_adv = 1'b1;
				end else begin
					ram_req.raddr = {row_q, i_q};
					state_d       = hdmb_pkg::S_CUR;
				end
			end
			hdmb_pkg::S_CUR: begin
				if (row_q == i_q) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = {row_q, row_q};
					ram_req.wdata = '0;
					i_adv         = 1'b1;
				end else if (relax_out.update) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = {row_q, i_q};
					ram_req.wdata = relax_out.cost;
					cost_d        = relax_out.cost;
					state_d       = hdmb_pkg::S_WR2;
				end else begin
					i_adv = 1'b1;
				end
			end
			hdmb_pkg::S_WR2: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = {i_q, row_q};
				ram_req.wdata = cost_q;
				i_adv         = 1'b1;
			end
			default: begin
				state_d = hdmb_pkg::S_IDLE;
			end
		endcase

		if (i_adv) begin
			if (i_q == n_last) begin
				scan_adv = 1'b1;
			end else begin
				i_d     = i_q + IW'(1);
				state_d = hdmb_pkg::S_HOP_RD;
			end
		end

		if (scan_adv) begin
			state_d = hdmb_pkg::S_SCAN_RD;
			if (col_q == n_last) begin
				col_d = '0;
				if (row_q == n_last) begin
					row_d = '0;
					if (turn_q == n_last) begin
						state_d = hdmb_pkg::S_IDLE;
					end else begin
						turn_d = turn_q + IW'(1);
					end
				end else begin
					row_d = row_q + IW'(1);
				end
			end else begin
				col_d = col_q + IW'(1);
			end
		end
	end

	a_done_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && cmd.opcode == hdmb_pkg::OP_READ))
		else $error("result strobe without an accepted read request");

	a_wr2_after_cur: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hdmb_pkg::S_WR2 |-> $past(state_q) == hdmb_pkg::S_CUR)
		else $error("mirror write not preceded by relax step");

	a_chk_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hdmb_pkg::S_SCAN_CHK |-> $past(state_q) == hdmb_pkg::S_SCAN_RD)
		else $error("scan check without scan read");

	a_turn_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hdmb_pkg::S_SCAN_RD |-> turn_q != '0 && CW'(turn_q) < n)
		else $error("build turn out of range");

endmodule

>>> rtl/hop_distance_matrix_builder_unit.sv
// Channel   Handshake                   Payload
// command   start, accepted when !busy  cmd (opcode, row_index, col_index, entry_value)
// result    done, one cycle, no stall   result (distance, index_ok)
// config    APB write, pready always 1  node_count at byte address 0
//
// A write is done in the cycle it is accepted; a read shows its result the next cycle.
// Clear sweeps the whole store, MAX_NODES*MAX_NODES entries (4096), one entry a cycle.
// Build, over n-1 turns: each scanned entry passes SCAN_RD, SCAN_CHK; one equal to the
// turn steps i via HOP_RD, HOP_CHK, CUR, WR2 as needed; all on the one store read port.
// After reset the store is cleared; busy stays high meanwhile.
// The result side cannot stall: done is high for exactly one cycle.
module hop_distance_matrix_builder_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  hdmb_pkg::hdmb_cmd_t                 cmd,
	output logic                                done,
	output hdmb_pkg::hdmb_result_t              result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [hdmb_pkg::PADDR_W-1:0]        paddr,
	input  logic [hdmb_pkg::PDATA_W-1:0]        pwdata,
	output logic [hdmb_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);

	localparam int CW = hdmb_pkg::CNT_W;
	localparam int MW = hdmb_pkg::CMP_W;
	localparam int GW = hdmb_pkg::CFG_W;
	localparam int DW = hdmb_pkg::PDATA_W;

	logic [GW-1:0]              node_count_q;
	logic [CW-1:0]              n;
	hdmb_pkg::hdmb_ram_req_t    ram_req;
	logic [hdmb_pkg::VAL_W-1:0] ram_rdata;
	hdmb_pkg::hdmb_relax_in_t   relax_in;
	hdmb_pkg::hdmb_relax_out_t  relax_out;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= hdmb_pkg::NODE_COUNT_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr == hdmb_pkg::ADDR_NODE_COUNT) begin
			node_count_q <= pwdata[GW-1:0];
		end
	end

	always_comb begin
		if (paddr == hdmb_pkg::ADDR_NODE_COUNT) begin
			prdata = DW'(node_count_q);
		end else begin
			prdata = '0;
		end
	end

	always_comb begin
		if (MW'(node_count_q) > MW'(hdmb_pkg::MAX_NODES)) begin
			n = CW'(hdmb_pkg::MAX_NODES);
		end else begin
			n = CW'(node_count_q);
		end
	end

	hdmb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.n         (n),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.relax_in  (relax_in),
		.relax_out (relax_out)
	);

	hdmb_relax u_relax (
		.rin  (relax_in),
		.rout (relax_out)
	);

	hdmb_ram #(
		.WIDTH (hdmb_pkg::VAL_W),
		.DEPTH (hdmb_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule
